// ===== src/fskuart_pkg.sv =====
// shared types and constants for the fsk uart modem framer
`default_nettype none

package fskuart_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_BIT_TICKS        = 2'd0,
        REG_HALF_BIT_TICKS   = 2'd1,
        REG_PERIOD_THRESHOLD = 2'd2,
        REG_UNUSED           = 2'd3
    } cfg_reg_t;

    // configuration reset values
    localparam logic [15:0] BIT_TICKS_RST        = 16'd833;
    localparam logic [15:0] HALF_BIT_TICKS_RST   = 16'd416;
    localparam logic [15:0] PERIOD_THRESHOLD_RST = 16'd16075;

    // demodulator status handed to the receive framer
    typedef struct packed {
        logic tone;       // tone bit after this tick's edge, 1 mark
        logic fall;       // mark-to-space change seen this tick
    } demod_stat_t;

endpackage

`default_nettype wire

// ===== src/fskuart_demod.sv =====
// tone demodulator: capture period compare and mark/space decision
`default_nettype none

module fskuart_demod
    import fskuart_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        advance,
    input  wire logic        edge_seen,
    input  wire logic [15:0] edge_time,
    input  wire logic [15:0] period_threshold,
    output demod_stat_t      stat
);

    logic [15:0] last_edge_reg, last_edge_next;
    logic        tone_reg, tone_next;
    logic [15:0] delta;

    // wrapped period between captures and tone decision
    always_comb begin
        delta          = edge_time - last_edge_reg;
        last_edge_next = last_edge_reg;
        tone_next      = tone_reg;
        if (edge_seen) begin
            last_edge_next = edge_time;
            tone_next      = (delta > period_threshold);
        end
        stat.tone = tone_next;
        stat.fall = edge_seen && tone_reg && !tone_next;
    end

    // capture state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_edge_reg <= '0;
            tone_reg      <= 1'b1;
        end else if (advance) begin
            last_edge_reg <= last_edge_next;
            tone_reg      <= tone_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/fskuart_rx.sv =====
// receive framer: start, data lsb first, odd parity and stop checks
`default_nettype none

module fskuart_rx
    import fskuart_pkg::*;
#(
    parameter int DATA_BITS   = 8,
    parameter int TIMER_WIDTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        advance,
    input  demod_stat_t      stat,
    input  wire logic [15:0] bit_ticks,
    input  wire logic [15:0] half_bit_ticks,
    output logic             rx_valid,
    output logic [7:0]       rx_byte
);

    typedef enum logic [2:0] {
        PH_IDLE, PH_START, PH_DATA, PH_PARITY, PH_STOP
    } rx_phase_t;

    localparam logic [3:0] LAST_COUNT = 4'(DATA_BITS);

    rx_phase_t              phase_reg, phase_next;
    logic [DATA_BITS-1:0]   shift_reg, shift_next;
    logic [3:0]             count_reg, count_next;
    logic [TIMER_WIDTH-1:0] timer_reg, timer_next;

    logic [TIMER_WIDTH+15:0] bit_ext, half_ext;
    logic [DATA_BITS+7:0]    byte_ext;
    logic                    expire;

    // period registers masked to the timer width
    assign bit_ext  = {{TIMER_WIDTH{1'b0}}, bit_ticks};
    assign half_ext = {{TIMER_WIDTH{1'b0}}, half_bit_ticks};
    assign byte_ext = {8'd0, shift_reg};

    // frame sequencing
    always_comb begin
        phase_next = phase_reg;
        shift_next = shift_reg;
        count_next = count_reg;
        timer_next = timer_reg;
        rx_valid   = 1'b0;
        rx_byte    = 8'd0;
        expire     = (timer_reg <= TIMER_WIDTH'(1));
        if (phase_reg == PH_IDLE) begin
            if (stat.fall) begin
                phase_next = PH_START;
                timer_next = half_ext[TIMER_WIDTH-1:0];
            end
        end else if (!expire) begin
            timer_next = timer_reg - TIMER_WIDTH'(1);
        end else begin
            timer_next = bit_ext[TIMER_WIDTH-1:0];
            unique case (phase_reg)
                PH_START: begin
                    if (!stat.tone) begin
                        shift_next = '0;
                        count_next = '0;
                        phase_next = PH_DATA;
                    end else begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_DATA: begin
                    for (int i = 0; i < DATA_BITS; i++) begin
                        if (count_reg == 4'(i))
                            shift_next[i] = shift_reg[i] | stat.tone;
                    end
                    count_next = count_reg + 4'd1;
                    if (count_next >= LAST_COUNT)
                        phase_next = PH_PARITY;
                end
                PH_PARITY: begin
                    phase_next = (stat.tone == ~^shift_reg) ? PH_STOP : PH_IDLE;
                end
                PH_STOP: begin
                    if (stat.tone) begin
                        rx_valid = 1'b1;
                        rx_byte  = byte_ext[7:0];
                    end
                    phase_next = PH_IDLE;
                end
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    // framer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            shift_reg <= '0;
            count_reg <= '0;
            timer_reg <= '0;
        end else if (advance) begin
            phase_reg <= phase_next;
            shift_reg <= shift_next;
            count_reg <= count_next;
            timer_reg <= timer_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/fskuart_tx.sv =====
// transmit framer: 8-o-1 style frame to mark/space tone
`default_nettype none

module fskuart_tx
    import fskuart_pkg::*;
#(
    parameter int DATA_BITS   = 8,
    parameter int TIMER_WIDTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        advance,
    input  wire logic        send_request,
    input  wire logic [7:0]  send_byte,
    input  wire logic [15:0] bit_ticks,
    output logic             tone_mark,
    output logic             tx_busy,
    output logic             send_accepted
);

    localparam int         FRAME_LEN  = DATA_BITS + 3;
    localparam logic [3:0] FRAME_LAST = 4'(FRAME_LEN);

    logic [FRAME_LEN-1:0]   shift_reg, shift_next;
    logic [3:0]             pos_reg, pos_next;
    logic                   active_reg, active_next;
    logic [TIMER_WIDTH-1:0] timer_reg, timer_next;

    logic [TIMER_WIDTH+15:0] bit_ext;
    logic [DATA_BITS+7:0]    data_ext;
    logic [DATA_BITS-1:0]    data;

    assign bit_ext  = {{TIMER_WIDTH{1'b0}}, bit_ticks};
    assign data_ext = {{DATA_BITS{1'b0}}, send_byte};
    assign data     = data_ext[DATA_BITS-1:0];

    // bit timing, then a new request when free
    always_comb begin
        shift_next    = shift_reg;
        pos_next      = pos_reg;
        active_next   = active_reg;
        timer_next    = timer_reg;
        send_accepted = 1'b0;
        if (active_reg) begin
            if (timer_reg <= TIMER_WIDTH'(1)) begin
                timer_next = bit_ext[TIMER_WIDTH-1:0];
                pos_next   = pos_reg + 4'd1;
                if (pos_next >= FRAME_LAST) begin
                    active_next = 1'b0;
                    pos_next    = '0;
                end
            end else begin
                timer_next = timer_reg - TIMER_WIDTH'(1);
            end
        end
        // a frame ending on this tick frees the transmitter for a request
        if (send_request && !active_next) begin
            shift_next    = {1'b1, ~^data, data, 1'b0};
            pos_next      = '0;
            active_next   = 1'b1;
            timer_next    = bit_ext[TIMER_WIDTH-1:0];
            send_accepted = 1'b1;
        end
        // tone for the current frame bit, idle mark otherwise
        tone_mark = 1'b1;
        if (active_next) begin
            for (int i = 0; i < FRAME_LEN; i++) begin
                if (pos_next == 4'(i))
                    tone_mark = shift_next[i];
            end
        end
        tx_busy = active_next;
    end

    // framer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg  <= '0;
            pos_reg    <= '0;
            active_reg <= 1'b0;
            timer_reg  <= '0;
        end else if (advance) begin
            shift_reg  <= shift_next;
            pos_reg    <= pos_next;
            active_reg <= active_next;
            timer_reg  <= timer_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/fsk_uart_modem_framer_top.sv =====
// top level of the fsk uart modem framer: registers, handshakes and framers
//
//  channel   direction  contents
//  s_*       in         one timebase tick: capture and send request
//  m_*       out        one result per tick: tone, status, received byte
//  cfg_*     in         register writes (bit, half bit, threshold)
//
//  one tick is taken per clock unless the m_ side stalls; a transfer passes through
//  the input register, then the result register
//  rate is set by the single pass through the framer logic between the registers
//  reset is synchronous on aresetn low; configuration returns to 833/416/16075
//  a stalled m_ side holds the result and stops the input register from advancing
`default_nettype none

module fsk_uart_modem_framer_top
    import fskuart_pkg::*;
#(
    parameter int DATA_BITS   = 8,
    parameter int TIMER_WIDTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input ticks
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // edge_time[15:0], send_byte[23:16]
    input  wire logic [1:0]  s_tuser,   // edge_seen[0], send_request[1]
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // tone_mark[0], tx_busy[1], send_accepted[2],
                                        // rx_byte[10:3], demod_bit[11], zero[15:12]
    output logic             m_tuser,   // rx_byte_valid[0]
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic        in_valid_reg;
    logic        edge_seen_reg, send_request_reg;
    logic [15:0] edge_time_reg;
    logic [7:0]  send_byte_reg;
    logic        advance;

    logic [15:0] bit_ticks_reg, half_bit_ticks_reg, period_threshold_reg;

    logic             out_valid_reg;
    logic [15:0]      out_data_reg;
    logic             out_user_reg;

    demod_stat_t stat;
    logic        rx_valid;
    logic [7:0]  rx_byte;
    logic        tone_mark, tx_busy, send_accepted;

    // handshakes
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_user_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_ticks_reg        <= BIT_TICKS_RST;
            half_bit_ticks_reg   <= HALF_BIT_TICKS_RST;
            period_threshold_reg <= PERIOD_THRESHOLD_RST;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_BIT_TICKS:        bit_ticks_reg        <= cfg_data;
                REG_HALF_BIT_TICKS:   half_bit_ticks_reg   <= cfg_data;
                REG_PERIOD_THRESHOLD: period_threshold_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            edge_seen_reg    <= s_tuser[0];
            send_request_reg <= s_tuser[1];
            edge_time_reg    <= s_tdata[15:0];
            send_byte_reg    <= s_tdata[23:16];
        end
    end

    fskuart_demod u_demod (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .advance          (advance),
        .edge_seen        (edge_seen_reg),
        .edge_time        (edge_time_reg),
        .period_threshold (period_threshold_reg),
        .stat             (stat)
    );

    fskuart_rx #(
        .DATA_BITS   (DATA_BITS),
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_rx (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .stat           (stat),
        .bit_ticks      (bit_ticks_reg),
        .half_bit_ticks (half_bit_ticks_reg),
        .rx_valid       (rx_valid),
        .rx_byte        (rx_byte)
    );

    fskuart_tx #(
        .DATA_BITS   (DATA_BITS),
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_tx (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .send_request  (send_request_reg),
        .send_byte     (send_byte_reg),
        .bit_ticks     (bit_ticks_reg),
        .tone_mark     (tone_mark),
        .tx_busy       (tx_busy),
        .send_accepted (send_accepted)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {4'd0, stat.tone, rx_byte, send_accepted, tx_busy, tone_mark};
            out_user_reg <= rx_valid;
        end
    end

endmodule

`default_nettype wire
